// ===== rtl/idrs_pkg.sv =====
package idrs_pkg;

   // date string layout
   localparam logic [3:0] DATE_LEN = 4'd10;
   localparam logic [3:0] SEP_A    = 4'd4;
   localparam logic [3:0] SEP_B    = 4'd7;
   localparam logic [3:0] POS_SAT  = 4'd11;

   // ascii codes
   localparam logic [7:0] CH_DASH = 8'h2D;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // reciprocal of 100 as a 19-bit fixed point fraction
   localparam logic [12:0] RECIP_100 = 13'd5243;
   localparam int          RECIP_SHIFT = 19;

   typedef logic [7:0]  char_type;
   typedef logic [13:0] year_type;
   typedef logic [6:0]  field_type;
   typedef logic [21:0] day_num_type;

   // one closed date string
   typedef struct packed {
      year_type  year;
      field_type month;
      field_type day;
      logic      good;
      logic      is_end;
   } date_entry_type;

   // days in the month of a common year
   function automatic logic [4:0] month_len(input field_type m);
      logic [4:0] len;
      case (m)
         7'd2:                   len = 5'd28;
         7'd4, 7'd6, 7'd9, 7'd11: len = 5'd30;
         default:                len = 5'd31;
      endcase
      return len;
   endfunction

   // days before the first of the month in a common year
   function automatic logic [8:0] days_before(input field_type m);
      logic [8:0] n;
      case (m)
         7'd1:    n = 9'd0;
         7'd2:    n = 9'd31;
         7'd3:    n = 9'd59;
         7'd4:    n = 9'd90;
         7'd5:    n = 9'd120;
         7'd6:    n = 9'd151;
         7'd7:    n = 9'd181;
         7'd8:    n = 9'd212;
         7'd9:    n = 9'd243;
         7'd10:   n = 9'd273;
         7'd11:   n = 9'd304;
         7'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

endpackage

// ===== rtl/idrs_req_if.sv =====
interface idrs_req_if;
   logic               valid;
   logic               ready;
   logic               has_char;
   idrs_pkg::char_type text_char;
   logic               string_end;

   modport source (output valid, has_char, text_char, string_end, input ready);
   modport sink (input valid, has_char, text_char, string_end, output ready);
endinterface

// ===== rtl/idrs_rsp_if.sv =====
interface idrs_rsp_if;
   logic                  valid;
   logic                  ready;
   logic                  range_valid;
   idrs_pkg::day_num_type span_days;

   modport source (output valid, range_valid, span_days, input ready);
   modport sink (input valid, range_valid, span_days, output ready);
endinterface

// ===== rtl/iso_date_range_day_span.sv =====
// path: an end date goes through the queue, then B_IDLE, B_MUL, B_SUM, B_OUT
// throughput: one word per cycle while the 2-entry date queue has room
// the day number converter takes a start date through B_IDLE, B_MUL and B_SUM,
// an end date also through B_OUT; short strings stall the input until the queue drains
// reset: synchronous, clears parse state, queue, converter and result valid
module iso_date_range_day_span import idrs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   idrs_req_if.sink   req_chan,
   idrs_rsp_if.source rsp_chan
);

   logic           push, pop, full, empty;
   date_entry_type push_data, pop_data;

   idrs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (full),
      .push       (push),
      .push_data  (push_data)
   );

   idrs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   idrs_back u_back (
      .clock    (clock),
      .reset    (reset),
      .empty    (empty),
      .pop_data (pop_data),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== rtl/idrs_front.sv =====
module idrs_front import idrs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   idrs_req_if.sink       req_chan,
   input  logic           queue_full,
   output logic           push,
   output date_entry_type push_data
);

   logic [3:0] pos_ff, pos_in;
   logic       on_end_ff, on_end_in;
   year_type   year_ff, year_in;
   field_type  month_ff, month_in;
   field_type  day_ff, day_in;
   logic       fmt_ff, fmt_in;
   logic       accept;
   logic [3:0] digit;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign digit          = 4'(req_chan.text_char - CH_ZERO);

   // per-word parse: check the byte against its place and fold in digits
   always_comb begin
      pos_in   = pos_ff;
      year_in  = year_ff;
      month_in = month_ff;
      day_in   = day_ff;
      fmt_in   = fmt_ff;
      if (accept && req_chan.has_char) begin
         if (pos_ff >= DATE_LEN) begin
            fmt_in = 1'b0;
         end else if (pos_ff == SEP_A || pos_ff == SEP_B) begin
            if (req_chan.text_char != CH_DASH) fmt_in = 1'b0;
         end else if (!(req_chan.text_char inside {[CH_ZERO:CH_NINE]})) begin
            fmt_in = 1'b0;
         end else if (pos_ff < SEP_A) begin
            year_in = 14'(year_ff * 14'd10 + 14'(digit));
         end else if (pos_ff < SEP_B) begin
            month_in = 7'(month_ff * 7'd10 + 7'(digit));
         end else begin
            day_in = 7'(day_ff * 7'd10 + 7'(digit));
         end
         if (pos_ff < POS_SAT) pos_in = 4'(pos_ff + 4'd1);
      end
   end

   // closing word hands the string to the back end
   assign push             = accept && req_chan.string_end;
   assign push_data.year   = year_in;
   assign push_data.month  = month_in;
   assign push_data.day    = day_in;
   assign push_data.good   = fmt_in && (pos_in == DATE_LEN);
   assign push_data.is_end = on_end_ff;
   assign on_end_in        = push ? !on_end_ff : on_end_ff;

   // string state, cleared when a string closes
   always_ff @(posedge clock) begin
      if (reset || push) begin
         pos_ff   <= 4'd0;
         year_ff  <= '0;
         month_ff <= '0;
         day_ff   <= '0;
         fmt_ff   <= 1'b1;
      end else begin
         pos_ff   <= pos_in;
         year_ff  <= year_in;
         month_ff <= month_in;
         day_ff   <= day_in;
         fmt_ff   <= fmt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_end_ff <= 1'b0;
      end else begin
         on_end_ff <= on_end_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) pos_ff <= POS_SAT)
      else $error("char position past saturation");

endmodule

// ===== rtl/idrs_queue.sv =====
module idrs_queue import idrs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  date_entry_type push_data,
   output logic           full,
   input  logic           pop,
   output date_entry_type pop_data,
   output logic           empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   date_entry_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]       count_ff;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   // entry storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
         end
         if (push && !pop) count_ff <= CNT_W'(count_ff + 1'b1);
         else if (pop && !push) count_ff <= CNT_W'(count_ff - 1'b1);
      end
   end

   assert property (@(posedge clock) disable iff (reset) !(push && full && !pop))
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("pop from empty queue");

endmodule

// ===== rtl/idrs_back.sv =====
module idrs_back import idrs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           empty,
   input  date_entry_type pop_data,
   output logic           pop,
   idrs_rsp_if.source     rsp_chan
);

   typedef enum logic [1:0] {B_IDLE, B_MUL, B_SUM, B_OUT} state_type;

   state_type   state_ff;
   year_type    year_ff;
   field_type   month_ff, day_ff;
   logic        good_ff, is_end_ff;
   logic [25:0] prod_ff;
   day_num_type y365_ff;
   day_num_type dn_ff, dn_in;
   logic        ok_ff, ok_in;
   day_num_type start_dn_ff;
   logic        start_good_ff;
   logic        rsp_valid_ff, rsp_range_ff;
   day_num_type rsp_span_ff;
   logic        load_rsp;

   logic [6:0]  q100, r100, ceil100;
   logic [11:0] ceil4;
   logic [4:0]  ceil400, dim;
   logic        leap, month_ok, day_ok, range_ok;

   assign pop = (state_ff == B_IDLE) && !empty;

   // leap rule and day number from the registered products
   always_comb begin
      q100     = prod_ff[25:RECIP_SHIFT];
      r100     = 7'(year_ff - 14'(q100) * 14'd100);
      ceil4    = 12'((15'(year_ff) + 15'd3) >> 2);
      ceil100  = 7'(q100 + 7'(r100 != '0));
      ceil400  = 5'(q100[6:2] + 5'((q100[1:0] != '0) || (r100 != '0)));
      leap     = ((year_ff[1:0] == '0) && (r100 != '0))
               || ((r100 == '0) && (q100[1:0] == '0));
      month_ok = month_ff inside {[7'd1:7'd12]};
      dim      = (month_ff == 7'd2 && leap) ? 5'd29 : month_len(month_ff);
      day_ok   = (day_ff != '0) && (day_ff <= 7'(dim));
      ok_in    = good_ff && month_ok && day_ok;
      dn_in    = 22'(y365_ff + 22'(ceil4) - 22'(ceil100) + 22'(ceil400)
               + 22'(days_before(month_ff)) + 22'(leap && month_ff > 7'd2)
               + 22'(day_ff) - 22'd1);
   end

   assign range_ok = ok_ff && start_good_ff && (start_dn_ff <= dn_ff);

   // result register loads once the previous word has left
   assign load_rsp = (state_ff == B_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   // conversion sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         start_good_ff <= 1'b0;
         start_dn_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            B_IDLE: begin
               if (!empty) begin
                  year_ff   <= pop_data.year;
                  month_ff  <= pop_data.month;
                  day_ff    <= pop_data.day;
                  good_ff   <= pop_data.good;
                  is_end_ff <= pop_data.is_end;
                  state_ff  <= B_MUL;
               end
            end
            B_MUL: begin
               prod_ff  <= 26'(year_ff) * 26'(RECIP_100);
               y365_ff  <= 22'(year_ff) * 22'd365;
               state_ff <= B_SUM;
            end
            B_SUM: begin
               dn_ff <= dn_in;
               ok_ff <= ok_in;
               if (is_end_ff) begin
                  state_ff <= B_OUT;
               end else begin
                  start_good_ff <= ok_in;
                  start_dn_ff   <= ok_in ? dn_in : '0;
                  state_ff      <= B_IDLE;
               end
            end
            B_OUT: begin
               if (load_rsp) begin
                  rsp_range_ff <= range_ok;
                  rsp_span_ff  <= range_ok ? 22'(dn_ff - start_dn_ff + 22'd1) : '0;
                  state_ff     <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.range_valid = rsp_range_ff;
   assign rsp_chan.span_days   = rsp_span_ff;

   assert property (@(posedge clock) disable iff (reset)
      state_ff == B_OUT |-> is_end_ff)
      else $error("result step for a start date");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_range_ff |-> rsp_span_ff != '0)
      else $error("valid range with zero span");

endmodule

// ===== dv/tb_iso_date_range_day_span.sv =====
`timescale 1ns / 100ps

module tb_iso_date_range_day_span;
   import idrs_pkg::*;

   localparam int TEXT_LEN     = 10;
   localparam int DASH_POS_A   = 4;
   localparam int DASH_POS_B   = 7;
   localparam int POS_LIMIT    = 11;
   localparam int ASCII_DASH   = 8'h2D;
   localparam int ASCII_ZERO   = 8'h30;
   localparam int ASCII_NINE   = 8'h39;
   localparam int RANDOM_WORDS = 750;
   localparam int DRAIN_CYCLES = 20;
   localparam int IDLE_LIMIT   = 1000;

   typedef char_type char_q_type[$];

   typedef struct packed {
      logic        range_ok;
      day_num_type span;
   } span_result_type;

   typedef enum {FLIP_BYTE, DROP_BYTE, EXTRA_BYTES, EMPTY_TEXT, JUNK_TEXT} garble_kind_type;

   // parses both date strings and keeps the spans still owed by the block
   class day_span_scoreboard;
      int              char_pos;
      bit              on_end_text;
      int              year_acc;
      int              month_acc;
      int              day_acc;
      bit              format_ok;
      int              start_number;
      bit              start_ok;
      int              errors;
      span_result_type expected_spans[$];

      function new();
         clear_text();
         on_end_text = 1'b0;
         start_number = 0;
         start_ok = 1'b0;
         errors = 0;
      endfunction

      static function bit is_leap(int y);
         return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
      endfunction

      static function int month_days(int y, int m);
         case (m)
            2: return is_leap(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default: return 31;
         endcase
      endfunction

      // days since 0000-01-01
      static function int day_number(int y, int m, int d);
         int n;
         n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + d - 1;
         for (int k = 1; k < m; k++)
            n += month_days(y, k);
         return n;
      endfunction

      function void clear_text();
         char_pos = 0;
         year_acc = 0;
         month_acc = 0;
         day_acc = 0;
         format_ok = 1'b1;
      endfunction

      task report(string msg);
         errors++;
         $display("%0t mismatch: %s", $realtime, msg);
      endtask

      function void note_word(logic has, char_type ch, logic fin);
         int              digit;
         bit              date_ok;
         int              number;
         span_result_type exp;
         // byte placement and digit accumulation
         if (has) begin
            if (char_pos >= TEXT_LEN) begin
               format_ok = 1'b0;
            end else if (char_pos == DASH_POS_A || char_pos == DASH_POS_B) begin
               if (ch != ASCII_DASH)
                  format_ok = 1'b0;
            end else if (ch < ASCII_ZERO || ch > ASCII_NINE) begin
               format_ok = 1'b0;
            end else begin
               digit = ch - ASCII_ZERO;
               if (char_pos < DASH_POS_A)
                  year_acc = (year_acc * 10 + digit) % 16384;
               else if (char_pos < DASH_POS_B)
                  month_acc = (month_acc * 10 + digit) % 128;
               else
                  day_acc = (day_acc * 10 + digit) % 128;
            end
            if (char_pos < POS_LIMIT)
               char_pos++;
         end
         if (!fin)
            return;
         // string closes
         date_ok = format_ok && char_pos == TEXT_LEN && month_acc >= 1 && month_acc <= 12
            && day_acc >= 1 && day_acc <= month_days(year_acc, month_acc);
         number = date_ok ? day_number(year_acc, month_acc, day_acc) : 0;
         clear_text();
         if (!on_end_text) begin
            start_ok = date_ok;
            start_number = number;
            on_end_text = 1'b1;
         end else begin
            on_end_text = 1'b0;
            if (date_ok && start_ok && start_number <= number)
               exp = '{1'b1, day_num_type'(number - start_number + 1)};
            else
               exp = '{1'b0, '0};
            expected_spans.push_back(exp);
         end
      endfunction

      task check_span(logic range_ok, day_num_type span);
         span_result_type exp;
         if (expected_spans.size() == 0) begin
            report($sformatf("unexpected result range_valid=%b span_days=%0d", range_ok, span));
            return;
         end
         exp = expected_spans.pop_front();
         if (range_ok !== exp.range_ok)
            report($sformatf("range_valid %b, want %b", range_ok, exp.range_ok));
         if (span !== exp.span)
            report($sformatf("span_days %0d, want %0d", span, exp.span));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   idrs_req_if req_if ();
   idrs_rsp_if rsp_if ();

   iso_date_range_day_span dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   day_span_scoreboard sb;
   bit  req_idle_on = 1'b1;
   bit  timed_out   = 1'b0;
   int  words_sent  = 0;
   int  idle_cycles = 0;
   int  edge_years[7] = '{0, 4, 100, 400, 1900, 2000, 9999};

   string directed_texts[28] = '{
      "0000-01-01", "9999-12-31",
      "2000-02-29", "2000-02-29",
      "1900-02-29", "1900-03-01",
      "0000-02-29", "0000-03-01",
      "2024-05-10", "2024-05-09",
      "",           "2024-01-01",
      "2024-1-01",  "2024-01-011",
      "2024-01-01-junk", "2024-02-30",
      "2O24-01-01", "2024/01/01",
      "2024-00-10", "2024-13-01",
      "2024-04-31", "2024-01-00",
      "1999-12-31", "2000-01-01",
      "2023-:1-01", "2023-01-32",
      "2024-01-15", ""
   };

   always #1 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      if (r < 93)
         return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic char_q_type to_chars(string s);
      char_q_type q;
      for (int i = 0; i < s.len(); i++)
         q.push_back(s[i]);
      return q;
   endfunction

   // well-formed text, sometimes with a month or day out of range
   function automatic string random_date_text();
      int y;
      int m;
      int d;
      int r;
      if ($urandom_range(0, 9) == 0)
         y = edge_years[$urandom_range(0, 6)];
      else
         y = $urandom_range(0, 9999);
      m = $urandom_range(1, 12);
      d = $urandom_range(1, day_span_scoreboard::month_days(y, m));
      r = $urandom_range(0, 99);
      if (r < 8)
         d = ($urandom_range(0, 2) == 0) ? 0 :
             $urandom_range(day_span_scoreboard::month_days(y, m) + 1, 99);
      else if (r < 14)
         m = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 99);
      return $sformatf("%04d-%02d-%02d", y, m, d);
   endfunction

   // broken strings: bad byte, wrong length, empty, junk
   function automatic char_q_type garble(char_q_type q);
      garble_kind_type kind;
      kind = garble_kind_type'($urandom_range(0, JUNK_TEXT));
      case (kind)
         FLIP_BYTE: begin
            if (q.size() > 0)
               q[$urandom_range(0, q.size() - 1)] = char_type'($urandom_range(0, 255));
         end
         DROP_BYTE: begin
            if (q.size() > 0)
               q.delete($urandom_range(0, q.size() - 1));
         end
         EXTRA_BYTES: begin
            repeat ($urandom_range(1, 4))
               q.push_back(($urandom_range(0, 1) == 0) ?
                           char_type'(ASCII_ZERO + $urandom_range(0, 9)) :
                           char_type'($urandom_range(0, 255)));
         end
         EMPTY_TEXT: q.delete();
         default: begin
            q.delete();
            repeat ($urandom_range(1, 14))
               q.push_back(char_type'($urandom_range(0, 255)));
         end
      endcase
      return q;
   endfunction

   // one word on the request channel, returns at the accepting edge
   task automatic send_word(input logic has, input char_type ch, input logic fin);
      int gap;
      gap = 0;
      if (req_idle_on && $urandom_range(0, 3) == 0)
         gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.has_char   <= has;
      req_if.text_char  <= ch;
      req_if.string_end <= fin;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      sb.note_word(has, ch, fin);
      if (has || fin)
         words_sent++;
   endtask

   // a date string, closed on its last byte or by an empty end word
   task automatic send_text(input char_q_type chars, input bit end_on_last);
      int n;
      n = chars.size();
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 39) == 0)
            send_word(1'b0, char_type'($urandom_range(0, 255)), 1'b0);
         send_word(1'b1, chars[i], end_on_last && i == n - 1);
      end
      if (!end_on_last || n == 0)
         send_word(1'b0, char_type'($urandom_range(0, 255)), 1'b1);
   endtask

   // result side back-pressure, switched on and off in stretches
   initial begin
      int stall_left;
      int stretch;
      bit stalls_on;
      stall_left = 0;
      stretch = 0;
      stalls_on = 1'b1;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stretch == 0) begin
            stalls_on = ($urandom_range(0, 3) != 0);
            stretch = $urandom_range(50, 300);
         end
         stretch--;
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (stalls_on && $urandom_range(0, 4) == 0) begin
            stall_left = pick_gap() - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_span(rsp_if.range_valid, rsp_if.span_days);
   end

   // cycles without any accepted word or result
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      char_q_type start_q;
      char_q_type end_q;
      sb = new();
      req_if.valid      <= 1'b0;
      req_if.has_char   <= 1'b0;
      req_if.text_char  <= '0;
      req_if.string_end <= 1'b0;
      reset <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      fork
         begin
            // directed strings, led by a word the block must ignore
            send_word(1'b0, 8'hFF, 1'b0);
            for (int i = 0; i < 28; i++)
               send_text(to_chars(directed_texts[i]), (i % 3) != 0);

            // random date pairs, some broken
            while (words_sent < RANDOM_WORDS) begin
               req_idle_on = ($urandom_range(0, 3) != 0);
               start_q = to_chars(random_date_text());
               if ($urandom_range(0, 99) < 15)
                  end_q = start_q;
               else
                  end_q = to_chars(random_date_text());
               if ($urandom_range(0, 99) < 12)
                  start_q = garble(start_q);
               if ($urandom_range(0, 99) < 12)
                  end_q = garble(end_q);
               send_text(start_q, 1'($urandom_range(0, 1)));
               send_text(end_q, 1'($urandom_range(0, 1)));
            end
            req_if.valid <= 1'b0;

            // drain outstanding results
            while (sb.expected_spans.size() != 0)
               @(posedge clock);
            repeat (DRAIN_CYCLES) @(posedge clock);
         end
         begin
            while (idle_cycles < IDLE_LIMIT)
               @(posedge clock);
            timed_out = 1'b1;
         end
      join_any

      if (timed_out)
         $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                  IDLE_LIMIT, sb.expected_spans.size());
      if (!timed_out && sb.errors == 0)
         $display("tb_iso_date_range_day_span: done, clean");
      else
         $display("tb_iso_date_range_day_span: done, errors");
      $finish;
   end

endmodule
